>>> design/twc_pkg.sv
// Shared types, constants and helper functions for the twelve-wheel stream cipher core.
// No dependencies; imported by twc_front, twc_back and the top level.
`timescale 1ns / 1ps

package twc_pkg;

    localparam int WHEEL_COUNT     = 12;
    localparam int WHEEL_W         = 61;
    localparam int POS_W           = 6;
    localparam int SYM_W           = 6;
    localparam int KEY_W           = 5;
    localparam int MODE_W          = 2;
    localparam int SEL_W           = 4;
    localparam int QUEUE_DEPTH_DEF = 2;

    // wheel numbering: chi1..chi5, mu1, mu2, psi1..psi5
    localparam int WHEEL_CHI0 = 0;
    localparam int WHEEL_MU1  = 5;
    localparam int WHEEL_MU2  = 6;
    localparam int WHEEL_PSI0 = 7;

    localparam logic [POS_W-1:0] WHEEL_LEN [WHEEL_COUNT] = '{
        6'd41, 6'd31, 6'd29, 6'd26, 6'd23, 6'd61,
        6'd37, 6'd43, 6'd47, 6'd51, 6'd53, 6'd59
    };
    localparam int WHEEL_HALF [WHEEL_COUNT] = '{1, 2, 3, 4, 5, 1, 2, 1, 2, 3, 4, 5};

    localparam logic [MODE_W-1:0] MODE_ENC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LF    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd3;

    localparam logic [SYM_W-1:0] LF_CODE = 6'd10;

    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_ENC   = 3'd0;
    localparam t_opcode OP_LF    = 3'd1;
    localparam t_opcode OP_START = 3'd2;
    localparam t_opcode OP_LOAD  = 3'd3;
    localparam t_opcode OP_NOP   = 3'd4;

    typedef struct packed {
        t_opcode              op;
        logic [SYM_W-1:0]     sym;
        logic [SEL_W-1:0]     sel;
        logic [WHEEL_W-1:0]   bits;
    } t_op;

    // square wave with the wheel's half period, cut to its length
    function automatic logic [WHEEL_W-1:0] default_pattern(input int w);
        logic [WHEEL_W-1:0] p;
        int                 cnt;
        logic               ph;
        p   = '0;
        cnt = 0;
        ph  = 1'b0;
        for (int n = 0; n < WHEEL_W; n++) begin
            if (n < int'(WHEEL_LEN[w])) begin
                p[n] = ph;
            end
            cnt = cnt + 1;
            if (cnt == WHEEL_HALF[w]) begin
                cnt = 0;
                ph  = ~ph;
            end
        end
        return p;
    endfunction

    function automatic logic [WHEEL_W-1:0] len_mask(input int w);
        logic [WHEEL_W-1:0] m;
        m = '0;
        for (int n = 0; n < WHEEL_W; n++) begin
            m[n] = (n < int'(WHEEL_LEN[w]));
        end
        return m;
    endfunction

    function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos, input int w);
        return (pos == WHEEL_LEN[w] - 6'd1) ? '0 : pos + 6'd1;
    endfunction

endpackage

>>> design/twc_front.sv
// Front end: takes input beats, classifies them into operations and queues them.
// Depends on twc_pkg.
`timescale 1ns / 1ps

module twc_front #(
    parameter int QUEUE_DEPTH = twc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [twc_pkg::MODE_W-1:0]   i_mode,
    input  logic [twc_pkg::SYM_W-1:0]    i_symbol_code,
    input  logic [twc_pkg::SEL_W-1:0]    i_wheel_select,
    input  logic [twc_pkg::WHEEL_W-1:0]  i_wheel_bits,
    output logic                         o_q_valid,
    output twc_pkg::t_op                 o_q_op,
    input  logic                         i_q_pop
);
    import twc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_op              r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_op              in_op;
    logic             push;
    logic             pop;

    always_comb begin
        in_op.sym  = i_symbol_code;
        in_op.sel  = i_wheel_select;
        in_op.bits = i_wheel_bits;
        case (i_mode)
            MODE_ENC:   in_op.op = OP_ENC;
            MODE_LF:    in_op.op = OP_LF;
            MODE_START: in_op.op = OP_START;
            MODE_LOAD:  in_op.op = (i_wheel_select < SEL_W'(WHEEL_COUNT)) ? OP_LOAD : OP_NOP;
            default:    in_op.op = OP_NOP;
        endcase
    end

    assign o_ready   = (r_count != CNT_FULL);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_op    = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_op;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");

    a_pop_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_count != '0)
        else $error("back end popped an empty queue");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue count missed a push");

endmodule

>>> design/twc_back.sv
// Back end: wheel patterns and positions, key generation and the result register.
// Depends on twc_pkg; fed by twc_front through its operation queue.
`timescale 1ns / 1ps

module twc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  twc_pkg::t_op                 i_q_op,
    output logic                         o_q_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [twc_pkg::SYM_W-1:0]    o_code_out,
    output logic                         o_is_line_break
);
    import twc_pkg::*;

    logic [WHEEL_W-1:0] r_pattern [WHEEL_COUNT];
    logic [POS_W-1:0]   r_pos     [WHEEL_COUNT];
    logic [POS_W-1:0]   n_pos     [WHEEL_COUNT];
    logic [POS_W-1:0]   psi_pos   [KEY_W];
    logic [KEY_W-1:0]   chi_bits;
    logic [KEY_W-1:0]   psi_bits;
    logic               mu1_bit;
    logic               mu2_bit;
    logic               has_result;
    logic               r_out_valid, n_out_valid;
    logic [SYM_W-1:0]   r_code;
    logic               r_lf;

    assign has_result = (i_q_op.op == OP_ENC) || (i_q_op.op == OP_LF);
    assign o_q_pop    = i_q_valid && (!has_result || !r_out_valid || i_ready);

    always_comb begin
        mu1_bit = r_pattern[WHEEL_MU1][r_pos[WHEEL_MU1]];
        mu2_bit = r_pattern[WHEEL_MU2][r_pos[WHEEL_MU2]];
        for (int w = 0; w < KEY_W; w++) begin
            // wheel 1 lands in the key MSB
            chi_bits[KEY_W-1-w] = r_pattern[WHEEL_CHI0+w][r_pos[WHEEL_CHI0+w]];
            psi_pos[w] = mu2_bit ? advance(r_pos[WHEEL_PSI0+w], WHEEL_PSI0+w)
                                 : r_pos[WHEEL_PSI0+w];
            psi_bits[KEY_W-1-w] = r_pattern[WHEEL_PSI0+w][psi_pos[w]];
        end
    end

    always_comb begin
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            n_pos[w] = r_pos[w];
        end
        if (o_q_pop) begin
            case (i_q_op.op)
                OP_ENC: begin
                    for (int w = 0; w < KEY_W; w++) begin
                        n_pos[WHEEL_CHI0+w] = advance(r_pos[WHEEL_CHI0+w], WHEEL_CHI0+w);
                        n_pos[WHEEL_PSI0+w] = psi_pos[w];
                    end
                    n_pos[WHEEL_MU1] = advance(r_pos[WHEEL_MU1], WHEEL_MU1);
                    if (mu1_bit) begin
                        n_pos[WHEEL_MU2] = advance(r_pos[WHEEL_MU2], WHEEL_MU2);
                    end
                end
                OP_LF: begin
                    for (int w = 0; w < KEY_W; w++) begin
                        n_pos[WHEEL_CHI0+w] = advance(advance(r_pos[WHEEL_CHI0+w],
                                                              WHEEL_CHI0+w), WHEEL_CHI0+w);
                    end
                    n_pos[WHEEL_MU1] = advance(advance(r_pos[WHEEL_MU1], WHEEL_MU1),
                                               WHEEL_MU1);
                end
                OP_START: begin
                    for (int w = 0; w < WHEEL_COUNT; w++) begin
                        n_pos[w] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (o_q_pop && has_result) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int w = 0; w < WHEEL_COUNT; w++) begin
                r_pos[w]     <= '0;
                r_pattern[w] <= default_pattern(w);
            end
        end else begin
            r_out_valid <= n_out_valid;
            for (int w = 0; w < WHEEL_COUNT; w++) begin
                r_pos[w] <= n_pos[w];
                if (o_q_pop && i_q_op.op == OP_LOAD && i_q_op.sel == SEL_W'(w)) begin
                    r_pattern[w] <= i_q_op.bits & len_mask(w);
                end
            end
        end
    end

    // result payload: load on a result-bearing pop
    always_ff @(posedge i_clk) begin
        if (o_q_pop && has_result) begin
            if (i_q_op.op == OP_LF) begin
                r_code <= LF_CODE;
                r_lf   <= 1'b1;
            end else begin
                r_code <= i_q_op.sym ^ {1'b0, chi_bits ^ psi_bits};
                r_lf   <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_code_out      = r_code;
    assign o_is_line_break = r_lf;

    function automatic logic positions_ok(input logic [POS_W-1:0] p [WHEEL_COUNT]);
        logic ok;
        ok = 1'b1;
        for (int w = 0; w < WHEEL_COUNT; w++) begin
            ok = ok && (p[w] < WHEEL_LEN[w]);
        end
        return ok;
    endfunction

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        positions_ok(r_pos))
        else $error("wheel position beyond wheel length");

    a_lf_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_lf) |-> r_code == LF_CODE)
        else $error("line break beat carries wrong code");

    a_start_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_op.op == OP_START) |=> r_pos[WHEEL_MU2] == '0 && r_pos[WHEEL_PSI0] == '0)
        else $error("start message left a position set");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(o_q_pop && has_result))
        else $error("result overwritten before it was taken");

endmodule

>>> design/twelve_wheel_teleprinter_stream_cipher_core.sv
// Top level of the twelve-wheel teleprinter stream cipher core.
// Depends on twc_pkg, twc_front and twc_back.
`timescale 1ns / 1ps

// Takes one item per clock while o_ready is high and, for symbol and line-break
// items, returns one result beat through the queue and then the result register
// when the output side is ready. Each item executes in the back end as it is
// popped, and all wheel positions that it moves are updated together; a short
// queue (QUEUE_DEPTH entries) separates input acceptance from execution, so stalls
// on the output side back up into the queue before o_ready drops. Start-message and
// load-pattern items give no result but still pass through the back end in order.
// Wheel patterns reset to the default alternating patterns and all positions to zero.
module twelve_wheel_teleprinter_stream_cipher_core #(
    parameter int QUEUE_DEPTH = twc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [twc_pkg::MODE_W-1:0]   i_mode,
    input  logic [twc_pkg::SYM_W-1:0]    i_symbol_code,
    input  logic [twc_pkg::SEL_W-1:0]    i_wheel_select,
    input  logic [twc_pkg::WHEEL_W-1:0]  i_wheel_bits,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [twc_pkg::SYM_W-1:0]    o_code_out,
    output logic                         o_is_line_break
);
    import twc_pkg::*;

    logic q_valid;
    t_op  q_op;
    logic q_pop;

    twc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_symbol_code  (i_symbol_code),
        .i_wheel_select (i_wheel_select),
        .i_wheel_bits   (i_wheel_bits),
        .o_q_valid      (q_valid),
        .o_q_op         (q_op),
        .i_q_pop        (q_pop)
    );

    twc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_op          (q_op),
        .o_q_pop         (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_code_out      (o_code_out),
        .o_is_line_break (o_is_line_break)
    );

endmodule
